[design/assert_macros.svh]
// assertion helpers, clocked on clk and disabled while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define TMA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define TMA_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) else $error(msg);

`endif

[design/tma_pkg.sv]
package tma_pkg;
	localparam int WINDOW_MAX_DEFAULT   = 64;
	localparam int SAMPLE_WIDTH_DEFAULT = 16;
	localparam int CFG_WIDTH            = 7;
	localparam int WINDOW_MIN           = 3;
	localparam logic [CFG_WIDTH-1:0] WINDOW_LENGTH_RESET = CFG_WIDTH'(8);
endpackage

[design/tma_if.sv]
interface tma_sample_if import tma_pkg::*; #(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT
) ();
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample;
	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface tma_average_if import tma_pkg::*; #(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT
) ();
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] average;
	modport source (output valid, output average, input ready);
	modport sink (input valid, input average, output ready);
endinterface

interface tma_cfg_if import tma_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_WIDTH-1:0] window_length;
	modport source (output valid, output window_length, input ready);
	modport sink (input valid, input window_length, output ready);
endinterface

[design/tma_ram.sv]
module tma_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[design/tma_divider.sv]
module tma_divider #(
	parameter int DW = 23,
	parameter int NW = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [NW-1:0] divisor,
	output logic [DW-1:0] quotient,
	output logic          done
);
	localparam int CNTW = $clog2(DW + 1);

	logic [NW-1:0]   rem_q;
	logic [DW-1:0]   quo_q;
	logic [NW-1:0]   div_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [NW:0]     shifted;
	logic            fits;
	logic [NW:0]     diff;

	// restoring division, one quotient bit per cycle
	assign shifted = {rem_q, quo_q[DW-1]};
	assign fits    = shifted >= {1'b0, div_q};
	assign diff    = shifted - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNTW'(1);
				if (cnt_q == CNTW'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[NW-1:0] : shifted[NW-1:0];
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;
endmodule

[design/trimmed_moving_average.sv]
// per sample: fill (while the window is not primed), write, scan, trim1, trim2, divgo, div,
//   finish; n the clamped window length, DW = SAMPLE_WIDTH + clog2(WINDOW_MAX) + 1
// a new sample is taken only in idle, after the previous result is loaded for output
// the scan reads all n window entries, the DW-bit bit-serial divider divides by n - 2
// reset: window length 8, window not primed, ring position 0; window ram is not cleared
`include "assert_macros.svh"

module trimmed_moving_average import tma_pkg::*; #(
	parameter int WINDOW_MAX   = WINDOW_MAX_DEFAULT,
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT
) (
	input logic           clk,
	input logic           arst_n,
	tma_cfg_if.sink       cfg,
	tma_sample_if.sink    samples,
	tma_average_if.source averages
);
	localparam int AW   = $clog2(WINDOW_MAX);
	localparam int NW   = $clog2(WINDOW_MAX + 1);
	localparam int CW   = (NW > CFG_WIDTH) ? NW : CFG_WIDTH;
	localparam int SUMW = SAMPLE_WIDTH + AW + 1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FILL,
		ST_WRITE,
		ST_SCAN,
		ST_TRIM1,
		ST_TRIM2,
		ST_DIVGO,
		ST_DIV,
		ST_FINISH
	} st_t;

	st_t                       state_q;
	logic [CFG_WIDTH-1:0]      window_length_q;
	logic                      primed_q;
	logic [AW-1:0]             widx_q;
	logic [NW-1:0]             n_q;
	logic [NW-1:0]             cnt_q;
	logic [SAMPLE_WIDTH-1:0]   s_q;
	logic signed [SUMW-1:0]    sum_q;
	logic signed [SAMPLE_WIDTH-1:0] lo_q;
	logic signed [SAMPLE_WIDTH-1:0] hi_q;
	logic                      first_q;
	logic                      rd_vld_s1;
	logic                      neg_q;
	logic                      out_valid_q;
	logic [SAMPLE_WIDTH-1:0]   average_q;

	logic [CW-1:0]             wl_ext;
	logic [NW-1:0]             n_eff;
	logic [NW-1:0]             widx_inc;
	logic [AW-1:0]             widx_next;
	logic                      ram_we;
	logic [AW-1:0]             ram_waddr;
	logic [AW-1:0]             ram_raddr;
	logic [SAMPLE_WIDTH-1:0]   ram_rdata;
	logic signed [SAMPLE_WIDTH-1:0] rd_val;
	logic [SUMW-1:0]           mag;
	logic                      div_start;
	logic                      div_done;
	logic [SUMW-1:0]           div_quo;
	logic [SUMW-1:0]           quo_fix;
	logic                      out_free;

	// clamp the programmed length into 3..WINDOW_MAX
	always_comb begin
		wl_ext = CW'(window_length_q);
		if (wl_ext < CW'(WINDOW_MIN)) begin
			n_eff = NW'(WINDOW_MIN);
		end else if (wl_ext > CW'(WINDOW_MAX)) begin
			n_eff = NW'(WINDOW_MAX);
		end else begin
			n_eff = wl_ext[NW-1:0];
		end
	end

	assign widx_inc  = NW'(widx_q) + NW'(1);
	assign widx_next = (widx_inc >= n_q) ? '0 : widx_inc[AW-1:0];

	assign ram_we    = (state_q == ST_FILL) || (state_q == ST_WRITE);
	assign ram_waddr = (state_q == ST_FILL) ? cnt_q[AW-1:0] : widx_next;
	assign ram_raddr = cnt_q[AW-1:0];

	tma_ram #(
		.WIDTH(SAMPLE_WIDTH),
		.DEPTH(WINDOW_MAX)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(s_q),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_val    = $signed(ram_rdata);
	assign mag       = sum_q[SUMW-1] ? (SUMW'(0) - $unsigned(sum_q)) : $unsigned(sum_q);
	assign div_start = (state_q == ST_DIVGO);

	tma_divider #(
		.DW(SUMW),
		.NW(NW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(mag),
		.divisor (n_q - NW'(2)),
		.quotient(div_quo),
		.done    (div_done)
	);

	assign quo_fix  = neg_q ? (SUMW'(0) - div_quo) : div_quo;
	assign out_free = !out_valid_q || averages.ready;

	assign cfg.ready        = 1'b1;
	assign samples.ready    = (state_q == ST_IDLE);
	assign averages.valid   = out_valid_q;
	assign averages.average = average_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			window_length_q <= WINDOW_LENGTH_RESET;
			primed_q        <= 1'b0;
			widx_q          <= '0;
			n_q             <= NW'(WINDOW_MIN);
			cnt_q           <= '0;
			first_q         <= 1'b0;
			rd_vld_s1       <= 1'b0;
			neg_q           <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				window_length_q <= cfg.window_length;
				primed_q        <= 1'b0;
			end
			// result held until taken, reloaded when finish hands over a new one
			out_valid_q <= ((state_q == ST_FINISH) && out_free) ||
				(out_valid_q && !averages.ready);
			rd_vld_s1 <= (state_q == ST_SCAN) && (cnt_q != n_q);

			case (state_q)
				ST_IDLE: begin
					if (samples.valid) begin
						s_q     <= samples.sample;
						n_q     <= n_eff;
						cnt_q   <= '0;
						state_q <= primed_q ? ST_WRITE : ST_FILL;
					end
				end
				ST_FILL: begin
					cnt_q <= cnt_q + NW'(1);
					if (cnt_q == n_q - NW'(1)) begin
						widx_q   <= '0;
						primed_q <= 1'b1;
						state_q  <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					widx_q  <= widx_next;
					cnt_q   <= '0;
					first_q <= 1'b1;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (cnt_q != n_q) begin
						cnt_q <= cnt_q + NW'(1);
					end
					if (rd_vld_s1) begin
						first_q <= 1'b0;
						if (first_q) begin
							sum_q <= SUMW'(rd_val);
							lo_q  <= rd_val;
							hi_q  <= rd_val;
						end else begin
							sum_q <= sum_q + SUMW'(rd_val);
							if (rd_val < lo_q) begin
								lo_q <= rd_val;
							end
							if (rd_val > hi_q) begin
								hi_q <= rd_val;
							end
						end
						if (cnt_q == n_q) begin
							state_q <= ST_TRIM1;
						end
					end
				end
				ST_TRIM1: begin
					sum_q   <= sum_q - SUMW'(hi_q);
					state_q <= ST_TRIM2;
				end
				ST_TRIM2: begin
					sum_q   <= sum_q - SUMW'(lo_q);
					state_q <= ST_DIVGO;
				end
				ST_DIVGO: begin
					neg_q   <= sum_q[SUMW-1];
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						average_q <= quo_fix[SAMPLE_WIDTH-1:0];
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`TMA_ASSERT(a_div_done_in_div, div_done |-> state_q == ST_DIV, "divider finished outside divide state")
	`TMA_ASSERT(a_ring_in_window, (primed_q && state_q == ST_IDLE) |-> NW'(widx_q) < n_eff, "ring position beyond window")
	`TMA_ASSERT(a_min_le_max, state_q == ST_TRIM1 |-> lo_q <= hi_q, "scan minimum above maximum")
	`TMA_ASSERT_NEXT(a_result_loaded, state_q == ST_FINISH && out_free, averages.valid && state_q == ST_IDLE, "result not presented after finish")
endmodule
